// File: rtl/core/wpp_pkg.sv
// ----------------------------------------------------------------------------
// wpp_pkg
// shared constants and types of the wheel position pid controller
// ----------------------------------------------------------------------------
package wpp_pkg;

  localparam int HistDepth   = 8;
  localparam int HistEntries = HistDepth - 1;
  localparam int PtrW        = (HistEntries > 1) ? $clog2(HistEntries) : 1;

  localparam int CountW = 32;
  localparam int GainW  = 16;
  localparam int ErrW   = 16;
  localparam int DriveW = 9;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam int DriveMax = 255;
  localparam int DriveMin = -255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P      = 2'd0,
    CFG_GAIN_I      = 2'd1,
    CFG_GAIN_D      = 2'd2,
    CFG_TARGET_RATE = 2'd3
  } cfg_reg_e;

endpackage

// File: rtl/core/wpp_ram.sv
// ----------------------------------------------------------------------------
// wpp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module wpp_ram #(
  parameter int Width = 32,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/wheel_position_pid.sv
// ----------------------------------------------------------------------------
// wheel_position_pid
// position pid controller for one wheel, one control tick per request
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_stall_o   encoder_count_i
//  out       output     out_valid_o / out_stall_i drive_o, wheel_speed_o
//  cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  one request per cycle unless the pipeline is full and the output is stalled;
//  each result passes the setpoint stage, multiply stage and sum and clamp stage
//  count history sits in a ram of depth-1 entries with per-entry valid bits,
//  reset makes every entry read as zero at once, no clearing pass
//  stages advance independently, so bubbles fill while the output is stalled
// ----------------------------------------------------------------------------
module wheel_position_pid (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [wpp_pkg::CountW-1:0] encoder_count_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [wpp_pkg::DriveW-1:0] drive_o,
  output logic signed [wpp_pkg::CountW-1:0] wheel_speed_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wpp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [wpp_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int CountW = wpp_pkg::CountW;
  localparam int GainW  = wpp_pkg::GainW;
  localparam int ErrW   = wpp_pkg::ErrW;
  localparam int PtrW   = wpp_pkg::PtrW;
  localparam int PW     = GainW + 1 + ErrW;
  localparam int DW     = GainW + 1 + ErrW + 1;
  localparam int IW     = GainW + 1 + CountW;
  localparam int SumW   = IW + 2;
  localparam logic signed [SumW-1:0] SumMax = SumW'(wpp_pkg::DriveMax);
  localparam logic signed [SumW-1:0] SumMin = SumW'(wpp_pkg::DriveMin);

  // configuration
  logic [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [GainW-1:0] target_rate_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q      <= '0;
      gain_i_q      <= '0;
      gain_d_q      <= '0;
      target_rate_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (wpp_pkg::cfg_reg_e'(cfg_index_i))
        wpp_pkg::CFG_GAIN_P:      gain_p_q      <= cfg_data_i;
        wpp_pkg::CFG_GAIN_I:      gain_i_q      <= cfg_data_i;
        wpp_pkg::CFG_GAIN_D:      gain_d_q      <= cfg_data_i;
        wpp_pkg::CFG_TARGET_RATE: target_rate_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // stage flow control
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_en, s2_en, s1_en, accept;

  assign out_en     = !out_valid_q || !out_stall_i;
  assign s2_en      = !s2_valid_q || out_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign accept     = in_valid_i && s1_en;
  assign in_stall_o = !s1_en;

  // count history ram
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [wpp_pkg::HistEntries-1:0] hist_vld_q;
  logic [CountW-1:0] hist_rdata;

  assign ptr_d = (ptr_q == PtrW'(wpp_pkg::HistEntries - 1)) ? '0 : ptr_q + 1'b1;

  wpp_ram #(
    .Width(CountW),
    .Depth(wpp_pkg::HistEntries)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(ptr_q),
    .wdata_i(encoder_count_i),
    .re_i   (accept),
    .raddr_i(ptr_q),
    .rdata_o(hist_rdata)
  );

  // scalar state and setpoint stage
  logic [CountW-1:0] target_pos_q, target_pos_d;
  logic [ErrW-1:0]   prev_err_q;
  logic [CountW-1:0] err_sum_q, err_sum_d;
  logic [ErrW-1:0]   err;
  logic [ErrW:0]     diff;

  assign target_pos_d = target_pos_q + {{(CountW-GainW){target_rate_q[GainW-1]}}, target_rate_q};
  assign err          = encoder_count_i[ErrW-1:0] - target_pos_d[ErrW+7:8];
  assign diff         = {err[ErrW-1], err} - {prev_err_q[ErrW-1], prev_err_q};
  assign err_sum_d    = err_sum_q + {{(CountW-ErrW){err[ErrW-1]}}, err};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q        <= '0;
      hist_vld_q   <= '0;
      target_pos_q <= '0;
      prev_err_q   <= '0;
      err_sum_q    <= '0;
    end else if (accept) begin
      ptr_q             <= ptr_d;
      hist_vld_q[ptr_q] <= 1'b1;
      target_pos_q      <= target_pos_d;
      prev_err_q        <= err;
      err_sum_q         <= err_sum_d;
    end
  end

  // stage 1 registers
  logic [CountW-1:0]        s1_count_q;
  logic                     s1_hvld_q;
  logic signed [ErrW-1:0]   s1_err_q;
  logic signed [ErrW:0]     s1_diff_q;
  logic signed [CountW-1:0] s1_esum_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_count_q <= encoder_count_i;
      s1_hvld_q  <= hist_vld_q[ptr_q];
      s1_err_q   <= err;
      s1_diff_q  <= diff;
      s1_esum_q  <= err_sum_q;
    end
  end

  // stage 2: products and speed
  logic signed [PW-1:0]     s2_p_q;
  logic signed [DW-1:0]     s2_d_q;
  logic signed [IW-1:0]     s2_i_q;
  logic [CountW-1:0]        s2_speed_q;
  logic [CountW-1:0]        oldest;

  assign oldest = s1_hvld_q ? hist_rdata : '0;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_en) begin
      s2_p_q     <= $signed({1'b0, gain_p_q}) * s1_err_q;
      s2_d_q     <= $signed({1'b0, gain_d_q}) * s1_diff_q;
      s2_i_q     <= $signed({1'b0, gain_i_q}) * s1_esum_q;
      s2_speed_q <= s1_count_q - oldest;
    end
  end

  // stage 3: sum, clamp, output register
  logic signed [SumW-1:0] sum;
  logic signed [wpp_pkg::DriveW-1:0] drive_sat;
  logic signed [wpp_pkg::DriveW-1:0] drive_q;
  logic [CountW-1:0] speed_q;

  assign sum = SumW'(s2_p_q) + SumW'(s2_d_q) + SumW'(s2_i_q);

  always_comb begin
    if (sum > SumMax) begin
      drive_sat = wpp_pkg::DriveW'(wpp_pkg::DriveMax);
    end else if (sum < SumMin) begin
      drive_sat = wpp_pkg::DriveW'(wpp_pkg::DriveMin);
    end else begin
      drive_sat = sum[wpp_pkg::DriveW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && out_en) begin
      drive_q <= drive_sat;
      speed_q <= s2_speed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_o       = drive_q;
  assign wheel_speed_o = speed_q;

`ifndef ASSERT_OFF
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_o <= 9'sd255 && drive_o >= -9'sd255))
    else $error("drive outside saturation range");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input accepted while pipeline is full and stalled");
`endif

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the wheel position pid controller
//
// A table of directed ticks and register writes comes first. Some of its rows
// carry hand-written results. Random phases follow, each with its own gains
// and setpoint rate, and then a short back-to-back run with the error pinned
// at its maximum while the setpoint climbs at full rate. Every tick the block
// accepts runs through a local model of the controller. Each result the block
// returns is checked field by field against the oldest pending prediction.
// Both sides idle and stall at random, and there is one long output hold-off
// and one drain pause in the middle of the traffic.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LatCycles  = 3;
  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 300;
  localparam int Phases     = 10;
  localparam int PhaseTicks = 50;
  localparam int WrapTicks  = 80;

  typedef struct packed {
    logic [wpp_pkg::DriveW-1:0] drive;
    logic [wpp_pkg::CountW-1:0] speed;
  } pid_result_t;

  typedef struct packed {
    bit          typed;
    pid_result_t res;
  } tick_note_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                    kind;
    wpp_pkg::cfg_reg_e            reg_sel;
    logic [wpp_pkg::CfgDataW-1:0] data;
    logic [wpp_pkg::CountW-1:0]   count;
    bit                           typed;
    pid_result_t                  res;
  } stim_row_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic signed [wpp_pkg::CountW-1:0] encoder_count_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [wpp_pkg::DriveW-1:0] drive_o;
  logic signed [wpp_pkg::CountW-1:0] wheel_speed_o;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [wpp_pkg::CfgIdxW-1:0]       cfg_index_i;
  logic [wpp_pkg::CfgDataW-1:0]      cfg_data_i;

  pid_result_t pending_outputs[$];
  tick_note_t  tick_notes[$];
  stim_row_t   stim_rows[$];

  logic [wpp_pkg::CountW-1:0] count_line [wpp_pkg::HistDepth];
  logic [31:0]                setpoint_q;
  logic [wpp_pkg::ErrW-1:0]   last_err_q;
  logic [31:0]                err_sum_q;
  logic [wpp_pkg::GainW-1:0]  kp_q, ki_q, kd_q;
  logic [15:0]                rate_q;

  logic [31:0] sp_track;
  logic [15:0] sent_rate;
  bit          quiet;
  bit          long_hold;
  int          mismatches   = 0;
  int          ticks_sent   = 0;
  int          results_seen = 0;
  int          cfg_writes   = 0;
  int          sat_seen     = 0;
  int          idle_cycles  = 0;

  wheel_position_pid i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .encoder_count_i (encoder_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_o         (drive_o),
    .wheel_speed_o   (wheel_speed_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic void pid_tick(input logic [wpp_pkg::CountW-1:0] cnt,
                                   output pid_result_t r);
    logic [wpp_pkg::ErrW-1:0] e16;
    longint                   err, derr, acc;
    int                       k;
    for (k = wpp_pkg::HistDepth - 1; k > 0; k--) count_line[k] = count_line[k-1];
    count_line[0] = cnt;
    r.speed = cnt - count_line[wpp_pkg::HistDepth-1];
    setpoint_q = setpoint_q + {{16{rate_q[15]}}, rate_q};
    e16  = cnt[15:0] - setpoint_q[23:8];
    err  = longint'(signed'(e16));
    derr = err - longint'(signed'(last_err_q));
    acc  = longint'(kp_q) * err + longint'(kd_q) * derr
         + longint'(ki_q) * longint'(signed'(err_sum_q));
    last_err_q = e16;
    err_sum_q  = err_sum_q + {{16{e16[15]}}, e16};
    if (acc > wpp_pkg::DriveMax) acc = wpp_pkg::DriveMax;
    if (acc < wpp_pkg::DriveMin) acc = wpp_pkg::DriveMin;
    r.drive = acc[wpp_pkg::DriveW-1:0];
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(99, 0);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [wpp_pkg::GainW-1:0] pick_gain();
    case ($urandom_range(4, 0))
      0:       return '0;
      1:       return 16'($urandom_range(3, 0));
      2:       return 16'($urandom_range(64, 0));
      3:       return 16'($urandom());
      default: return '1;
    endcase
  endfunction

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(4, 0))
      0:       return '0;
      1:       return 16'($urandom_range(1024, 0)) - 16'd512;
      2:       return 16'($urandom());
      3:       return 16'h7fff;
      default: return 16'h8000;
    endcase
  endfunction

  // half the counts lie near the setpoint so the drive leaves saturation
  function automatic logic [wpp_pkg::CountW-1:0] pick_count();
    logic [wpp_pkg::CountW-1:0] c;
    logic [31:0]                sp_next;
    int                         r;
    sp_next = sp_track + {{16{sent_rate[15]}}, sent_rate};
    r = $urandom_range(99, 0);
    c = $urandom();
    if (r < 50) begin
      c[15:0] = sp_next[23:8] + 16'($urandom_range(16, 0)) - 16'd8;
    end else if (r < 70) begin
      case ($urandom_range(3, 0))
        0:       c = 32'h0000_0000;
        1:       c = 32'h7fff_ffff;
        2:       c = 32'h8000_0000;
        default: c = 32'hffff_ffff;
      endcase
    end
    return c;
  endfunction

  function automatic void add_tick(input logic [wpp_pkg::CountW-1:0] c, input bit typed,
                                   input logic [wpp_pkg::DriveW-1:0] drv,
                                   input logic [wpp_pkg::CountW-1:0] spd);
    stim_row_t row;
    row.kind      = ROW_TICK;
    row.reg_sel   = wpp_pkg::CFG_GAIN_P;
    row.data      = '0;
    row.count     = c;
    row.typed     = typed;
    row.res.drive = drv;
    row.res.speed = spd;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input wpp_pkg::cfg_reg_e r,
                                  input logic [wpp_pkg::CfgDataW-1:0] d);
    stim_row_t row;
    row.kind    = ROW_CFG;
    row.reg_sel = r;
    row.data    = d;
    row.count   = '0;
    row.typed   = 1'b0;
    row.res     = '0;
    stim_rows.push_back(row);
  endfunction

  task automatic settle();
    @(posedge clk_i);
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (LatCycles + 1) @(posedge clk_i);
  endtask

  task automatic write_reg(input wpp_pkg::cfg_reg_e r,
                           input logic [wpp_pkg::CfgDataW-1:0] d);
    in_valid_i <= 1'b0;
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (r == wpp_pkg::CFG_TARGET_RATE) sent_rate = d;
  endtask

  // hold a request until the block takes it, then maybe leave a gap
  task automatic send_tick(input logic [wpp_pkg::CountW-1:0] cnt, input bit typed,
                           input pid_result_t res);
    tick_note_t n;
    int         gap;
    n.typed = typed;
    n.res   = res;
    tick_notes.push_back(n);
    sp_track = sp_track + {{16{sent_rate[15]}}, sent_rate};
    in_valid_i      <= 1'b1;
    encoder_count_i <= cnt;
    ticks_sent++;
    do @(posedge clk_i); while (in_stall_o);
    gap = rand_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    pid_result_t pred;
    pid_result_t got;
    tick_note_t  note;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          wpp_pkg::CFG_GAIN_P:      kp_q   = cfg_data_i;
          wpp_pkg::CFG_GAIN_I:      ki_q   = cfg_data_i;
          wpp_pkg::CFG_GAIN_D:      kd_q   = cfg_data_i;
          wpp_pkg::CFG_TARGET_RATE: rate_q = cfg_data_i;
          default: ;
        endcase
        cfg_writes++;
      end
      if (in_valid_i && !in_stall_o) begin
        pid_tick(encoder_count_i, pred);
        note = tick_notes.pop_front();
        pending_outputs.push_back(note.typed ? note.res : pred);
      end
      if (out_valid_o && !out_stall_i) begin
        got.drive = drive_o;
        got.speed = wheel_speed_o;
        results_seen++;
        if (got.drive == 9'(wpp_pkg::DriveMax) || got.drive == 9'(wpp_pkg::DriveMin))
          sat_seen++;
        if (pending_outputs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d with nothing pending: drive %0d speed %0d",
                     results_seen, drive_o, wheel_speed_o);
        end else begin
          pred = pending_outputs.pop_front();
          if (got.drive !== pred.drive || got.speed !== pred.speed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: drive exp %0d got %0d, speed exp %0d got %0d",
                       results_seen, $signed(pred.drive), $signed(got.drive),
                       $signed(pred.speed), $signed(got.speed));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= IdleLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : receiver
    int hold_len;
    int free_len;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      free_len = $urandom_range(8, 1);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        for (hold_len = 0; hold_len < HoldCycles; hold_len++) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        hold_len = rand_gap();
        if (hold_len > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold_len) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      repeat (free_len) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int                         phase;
    int                         n;
    int                         k;
    logic [wpp_pkg::CountW-1:0] cnt;
    logic [31:0]                sp_next;
    logic [wpp_pkg::GainW-1:0]  gp, gi, gd;
    logic [15:0]                rt;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    encoder_count_i <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= wpp_pkg::CFG_GAIN_P;
    cfg_data_i      <= '0;
    quiet     = 1'b0;
    long_hold = 1'b0;
    sp_track  = '0;
    sent_rate = '0;
    kp_q = '0; ki_q = '0; kd_q = '0; rate_q = '0;
    setpoint_q = '0; last_err_q = '0; err_sum_q = '0;
    for (k = 0; k < wpp_pkg::HistDepth; k++) count_line[k] = '0;

    // zero gains after reset: drive is zero, speed is the count itself
    add_tick(32'h0000_0000, 1'b1, '0, 32'h0000_0000);
    add_tick(32'h7fff_ffff, 1'b1, '0, 32'h7fff_ffff);
    add_tick(32'h8000_0000, 1'b1, '0, 32'h8000_0000);
    add_tick(32'hffff_ffff, 1'b1, '0, 32'hffff_ffff);
    add_tick(32'h0000_0001, 1'b1, '0, 32'h0000_0001);
    add_tick(32'h0000_8000, 1'b1, '0, 32'h0000_8000);
    add_tick(32'h0000_7fff, 1'b1, '0, 32'h0000_7fff);
    add_cfg(wpp_pkg::CFG_GAIN_P, 16'hffff);
    add_tick(32'h0000_7fff, 1'b1, 9'(wpp_pkg::DriveMax), 32'h0000_7fff);
    add_tick(32'h0000_8000, 1'b0, '0, '0);
    add_cfg(wpp_pkg::CFG_GAIN_P, 16'h0000);
    add_cfg(wpp_pkg::CFG_GAIN_D, 16'hffff);
    add_tick(32'h0000_8000, 1'b0, '0, '0);
    add_tick(32'h0000_7fff, 1'b0, '0, '0);
    add_cfg(wpp_pkg::CFG_GAIN_D, 16'h0000);
    add_cfg(wpp_pkg::CFG_GAIN_I, 16'hffff);
    add_tick(32'h0000_7fff, 1'b0, '0, '0);
    add_tick(32'h0000_7fff, 1'b0, '0, '0);
    add_tick(32'h0000_8000, 1'b0, '0, '0);
    add_cfg(wpp_pkg::CFG_GAIN_I, 16'h0001);
    add_cfg(wpp_pkg::CFG_GAIN_P, 16'h0001);
    add_cfg(wpp_pkg::CFG_GAIN_D, 16'h0001);
    add_cfg(wpp_pkg::CFG_TARGET_RATE, 16'h7fff);
    add_tick(32'ha5a5_1234, 1'b0, '0, '0);
    add_tick(32'h5a5a_edcb, 1'b0, '0, '0);
    add_cfg(wpp_pkg::CFG_TARGET_RATE, 16'h8000);
    add_tick(32'h0000_0000, 1'b0, '0, '0);
    add_tick(32'hffff_ffff, 1'b0, '0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < stim_rows.size(); k++) begin
      if (stim_rows[k].kind == ROW_CFG)
        write_reg(stim_rows[k].reg_sel, stim_rows[k].data);
      else
        send_tick(stim_rows[k].count, stim_rows[k].typed, stim_rows[k].res);
    end

    for (phase = 0; phase < Phases; phase++) begin
      case (phase)
        0: begin gp = '1; gi = '1; gd = '1; rt = 16'h7fff; end
        1: begin gp = '0; gi = '0; gd = '0; rt = 16'h8000; end
        2: begin gp = 16'd1; gi = 16'd0; gd = 16'd1; rt = 16'h0100; end
        default: begin
          gp = pick_gain(); gi = pick_gain(); gd = pick_gain(); rt = pick_rate();
        end
      endcase
      write_reg(wpp_pkg::CFG_GAIN_P, gp);
      write_reg(wpp_pkg::CFG_GAIN_I, gi);
      write_reg(wpp_pkg::CFG_GAIN_D, gd);
      write_reg(wpp_pkg::CFG_TARGET_RATE, rt);
      quiet = (phase == 3);
      if (phase == 5) long_hold = 1'b1;
      for (n = 0; n < PhaseTicks; n++) begin
        if (phase == 7 && n == PhaseTicks / 2) begin
          in_valid_i <= 1'b0;
          settle();
        end
        send_tick(pick_count(), 1'b0, '0);
      end
    end
    quiet = 1'b0;

    // error pinned at its maximum while the setpoint climbs at full rate
    write_reg(wpp_pkg::CFG_GAIN_P, 16'h0000);
    write_reg(wpp_pkg::CFG_GAIN_I, 16'h0001);
    write_reg(wpp_pkg::CFG_GAIN_D, 16'h0000);
    write_reg(wpp_pkg::CFG_TARGET_RATE, 16'h7fff);
    quiet = 1'b1;
    for (n = 0; n < WrapTicks; n++) begin
      sp_next = sp_track + {{16{sent_rate[15]}}, sent_rate};
      cnt[31:16] = 16'($urandom());
      cnt[15:0]  = sp_next[23:8] + 16'h7fff;
      send_tick(cnt, 1'b0, '0);
    end
    quiet = 1'b0;

    in_valid_i <= 1'b0;
    settle();

    $display("sent %0d ticks, checked %0d results, %0d register writes, %0d saturated drives",
             ticks_sent, results_seen, cfg_writes, sat_seen);
    $display("random phases plus %0d back-to-back ticks with the error held at its peak",
             WrapTicks);
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
